### design/b64_pkg.sv
// b64_pkg: shared types and constants of the base64url stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package b64_pkg;

  // default width of the output byte budget register
  localparam int DEF_COUNT_WIDTH = 16;

  // depth of the group queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // status codes on the last result of a message
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // special characters
  localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'

  // sextet values of the two symbol characters
  localparam logic [5:0] SX_DASH  = 6'd62;
  localparam logic [5:0] SX_UNDER = 6'd63;

  // character classes
  localparam logic [1:0] CL_DATA = 2'd0;
  localparam logic [1:0] CL_PAD  = 2'd1;
  localparam logic [1:0] CL_BAD  = 2'd2;

  // input beat
  typedef struct packed {
    logic [7:0] in_char;
    logic       is_final;
  } b64_in_t;

  // result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    logic [1:0] status;
  } b64_out_t;

  // one decoded group as queued between front and back
  typedef struct packed {
    logic [23:0] word;    // three bytes, first byte in the top bits
    logic [1:0]  cnt;     // number of result beats, 1 to 3
    logic        has;     // beats carry bytes
    logic        eom;     // group ends the message
    logic [1:0]  status;  // status on the last beat
  } b64_rec_t;

endpackage

`default_nettype wire

### design/b64_front.sv
// b64_front: accepts characters, classifies them, tracks group and message
// state; one record per clean inner group or message end. uses b64_pkg
`default_nettype none

module b64_front
  import b64_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire b64_in_t                in_item,
  input  wire logic                   cfg_write,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data,
  output b64_rec_t                    rec,
  output logic                        rec_valid
);

  localparam int CW = COUNT_WIDTH + 1;  // bytes_decoded width
  localparam int SW = COUNT_WIDTH + 2;  // sum width

  logic [COUNT_WIDTH-1:0] max_out_bytes;
  logic [17:0]            group_bits, group_bits_next;
  logic [1:0]             group_position, group_position_next;
  logic [1:0]             pad_seen, pad_seen_next;
  logic                   bad_char_seen, bad_char_seen_next;
  logic [CW-1:0]          bytes_decoded, bytes_decoded_next;

  logic [1:0]  cls;
  logic [5:0]  sx;
  logic [23:0] word;
  logic [1:0]  n_bytes;
  logic [SW-1:0] sum3;
  logic [SW-1:0] total;

  // character to class and sextet
  always_comb begin
    cls = CL_DATA;
    sx  = 6'd0;
    if (in_item.in_char >= "A" && in_item.in_char <= "Z") begin
      sx = 6'(in_item.in_char - "A");
    end else if (in_item.in_char >= "a" && in_item.in_char <= "z") begin
      sx = 6'(in_item.in_char - "a" + 8'd26);
    end else if (in_item.in_char >= "0" && in_item.in_char <= "9") begin
      sx = 6'(in_item.in_char - "0" + 8'd52);
    end else if (in_item.in_char == CH_DASH) begin
      sx = SX_DASH;
    end else if (in_item.in_char == CH_UNDER) begin
      sx = SX_UNDER;
    end else if (in_item.in_char == CH_PAD) begin
      cls = CL_PAD;
    end else begin
      cls = CL_BAD;
    end
  end

  assign word = {group_bits, sx};
  assign sum3 = {1'b0, bytes_decoded} + SW'(3);

  // next state and group record
  always_comb begin
    group_bits_next     = group_bits;
    group_position_next = group_position;
    pad_seen_next       = pad_seen;
    bad_char_seen_next  = bad_char_seen;
    bytes_decoded_next  = bytes_decoded;
    rec                 = '0;
    rec_valid           = 1'b0;
    n_bytes             = 2'd3;
    total               = '0;

    if (accept) begin
      // padding and bad character tracking
      case (cls)
        CL_BAD: begin
          bad_char_seen_next = 1'b1;
          pad_seen_next      = 2'd0;
        end
        CL_PAD: begin
          if (group_position < 2'd2) begin
            bad_char_seen_next = 1'b1;
          end
          pad_seen_next = (pad_seen >= 2'd2) ? 2'd2 : pad_seen + 2'd1;
        end
        default: begin
          if (pad_seen != 2'd0) begin
            bad_char_seen_next = 1'b1;
          end
          pad_seen_next = 2'd0;
        end
      endcase

      n_bytes = (pad_seen_next == 2'd0) ? 2'd3 :
                (pad_seen_next == 2'd1) ? 2'd2 : 2'd1;
      total   = {1'b0, bytes_decoded} + SW'(n_bytes);

      if (group_position != 2'd3) begin
        // group still filling
        group_bits_next     = word[17:0];
        group_position_next = group_position + 2'd1;
        if (in_item.is_final) begin
          rec.cnt    = 2'd1;
          rec.eom    = 1'b1;
          rec.status = ST_BAD_LEN;
          rec_valid  = 1'b1;
        end
      end else if (!in_item.is_final) begin
        // inner group complete
        group_bits_next     = '0;
        group_position_next = 2'd0;
        if (pad_seen_next != 2'd0) begin
          bad_char_seen_next = 1'b1;
        end
        bytes_decoded_next = sum3[SW-1] ? '1 : sum3[CW-1:0];
        if (!bad_char_seen_next) begin
          rec.word  = word;
          rec.cnt   = 2'd3;
          rec.has   = 1'b1;
          rec_valid = 1'b1;
        end
      end else begin
        // last group of the message
        rec_valid = 1'b1;
        rec.eom   = 1'b1;
        if (total > SW'(max_out_bytes)) begin
          rec.cnt    = 2'd1;
          rec.status = ST_TOO_LONG;
        end else if (bad_char_seen_next) begin
          rec.cnt    = 2'd1;
          rec.status = ST_BAD_CHAR;
        end else begin
          rec.word   = word;
          rec.cnt    = n_bytes;
          rec.has    = 1'b1;
          rec.status = ST_OK;
        end
      end

      // message done: clear all message state
      if (in_item.is_final) begin
        group_bits_next     = '0;
        group_position_next = 2'd0;
        pad_seen_next       = 2'd0;
        bad_char_seen_next  = 1'b0;
        bytes_decoded_next  = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits     <= '0;
      group_position <= 2'd0;
      pad_seen       <= 2'd0;
      bad_char_seen  <= 1'b0;
      bytes_decoded  <= '0;
    end else begin
      group_bits     <= group_bits_next;
      group_position <= group_position_next;
      pad_seen       <= pad_seen_next;
      bad_char_seen  <= bad_char_seen_next;
      bytes_decoded  <= bytes_decoded_next;
    end
  end

  // byte budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_bytes <= '1;
    end else if (cfg_write) begin
      max_out_bytes <= cfg_data;
    end
  end

endmodule

`default_nettype wire

### design/b64_fifo.sv
// b64_fifo: short queue of group records between front and back
// uses b64_pkg for the record type and depth
`default_nettype none

module b64_fifo
  import b64_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_en,
  input  wire b64_rec_t wr_data,
  input  wire logic     rd_en,
  output b64_rec_t      rd_data,
  output logic          full,
  output logic          empty
);

  b64_rec_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full    = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/b64_back.sv
// b64_back: splits the head group record into one to three result beats
// uses b64_pkg for the record and result types
`default_nettype none

module b64_back
  import b64_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire b64_rec_t head,
  input  wire logic     head_valid,
  input  wire logic     pop,
  output b64_out_t      out_item,
  output logic          head_done
);

  logic [1:0] idx;
  logic       last;
  logic [7:0] sel_byte;

  assign last = (idx == head.cnt - 2'd1);

  // byte of the current beat
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.word[23:16];
      2'd1:    sel_byte = head.word[15:8];
      default: sel_byte = head.word[7:0];
    endcase
  end

  // result beat
  always_comb begin
    out_item.data_byte      = head.has ? sel_byte : 8'd0;
    out_item.has_byte       = head.has;
    out_item.end_of_message = head.eom && last;
    out_item.status         = last ? head.status : ST_OK;
  end

  assign head_done = pop && head_valid && last;

  // beat index within the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && head_valid) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

### design/base64url_stream_decoder.sv
// base64url_stream_decoder: top level, front decoder, group queue, beat splitter
// uses b64_pkg, b64_front, b64_fifo, b64_back
//
//   channel   handshake        payload                      beat
//   input     push / full      in_item (b64_in_t)           one character
//   result    pop / empty      out_item (b64_out_t)         one byte or status
//   config    cfg_write        cfg_data                     max_out_bytes
//
// one character is taken per cycle while not full; a finished group is decoded
// in the cycle its fourth character is taken and, unless a bad inner group,
// queued as one record (depth 4). a record drains as one to three result beats,
// one per cycle of pop. full rises only when the group queue holds four records.
// reset is synchronous; max_out_bytes resets to all ones, all else to empty.
`default_nettype none

module base64url_stream_decoder
  import b64_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire b64_in_t                in_item,
  input  wire logic                   push,
  output logic                        full,
  output b64_out_t                    out_item,
  output logic                        empty,
  input  wire logic                   pop,
  input  wire logic                   cfg_write,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data
);

  b64_rec_t rec;
  logic     rec_valid;
  b64_rec_t head;
  logic     q_full;
  logic     q_empty;
  logic     head_done;

  assign full  = q_full;
  assign empty = q_empty;

  // character decode and message state
  b64_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (push && !q_full),
    .in_item  (in_item),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .rec      (rec),
    .rec_valid(rec_valid)
  );

  // group queue
  b64_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rec_valid),
    .wr_data(rec),
    .rd_en  (head_done),
    .rd_data(head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // result beats
  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(!q_empty),
    .pop       (pop),
    .out_item  (out_item),
    .head_done (head_done)
  );

endmodule

`default_nettype wire

### design/b64_checker.sv
// b64_checker: port-level checks of the base64url stream decoder
// uses b64_pkg; bound to base64url_stream_decoder at the end of this file
`default_nettype none

module b64_checker
  import b64_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire b64_out_t out_item,
  input wire logic     empty,
  input wire logic     full
);

  // an error status only appears on the last beat of a message
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status != ST_OK) |-> out_item.end_of_message)
    else $error("status on a beat that does not end the message");

  // an error beat never carries a byte
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status != ST_OK) |-> !out_item.has_byte)
    else $error("error beat carries a byte");

  // a beat without a byte is the end of a message with zero data
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.has_byte) |->
      (out_item.end_of_message && out_item.data_byte == 8'd0))
    else $error("empty beat that is not a final status beat");

  // reset leaves the block with nothing queued and room to accept
  assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not empty after reset");

endmodule

bind base64url_stream_decoder b64_checker u_b64_checker (
  .clk     (clk),
  .rst     (rst),
  .out_item(out_item),
  .empty   (empty),
  .full    (full)
);

`default_nettype wire

### sim/base64url_stream_decoder_test.sv
`timescale 1ns / 1ps
// base64url_stream_decoder_test: self-checking bench for the base64url stream decoder
// depends on b64_pkg and base64url_stream_decoder; directed table, then random messages

module base64url_stream_decoder_test;
  import b64_pkg::*;

  localparam int COUNT_WIDTH   = DEF_COUNT_WIDTH;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_BEATS   = 20;
  localparam int N_ROWS        = 25;
  localparam logic [COUNT_WIDTH:0] COUNT_ALL = '1;

  // one row of the directed table; pinned rows carry a typed-in error status
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       pinned;
    logic [1:0] st;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  b64_in_t                in_item = '0;
  logic                   push = 1'b0;
  logic                   full;
  b64_out_t               out_item;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [COUNT_WIDTH-1:0] cfg_data = '0;

  // decoder state as predicted
  logic [17:0]            grp_bits;
  logic [1:0]             grp_pos;
  logic [1:0]             pad_run;
  logic                   bad_flag;
  logic [COUNT_WIDTH:0]   byte_count;
  logic [COUNT_WIDTH-1:0] byte_limit;
  b64_out_t               expected_beats[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned chars_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  stim_row_t   directed_rows[N_ROWS];

  base64url_stream_decoder #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // character class and sextet; '=' and bad characters decode as zero
  function automatic logic [1:0] classify_char(input logic [7:0] c, output logic [5:0] sx);
    sx = 6'd0;
    if (c >= "A" && c <= "Z") begin
      sx = 6'(c - "A");
      return CL_DATA;
    end
    if (c >= "a" && c <= "z") begin
      sx = 6'(c - "a" + 26);
      return CL_DATA;
    end
    if (c >= "0" && c <= "9") begin
      sx = 6'(c - "0" + 52);
      return CL_DATA;
    end
    if (c == CH_DASH) begin
      sx = SX_DASH;
      return CL_DATA;
    end
    if (c == CH_UNDER) begin
      sx = SX_UNDER;
      return CL_DATA;
    end
    if (c == CH_PAD) return CL_PAD;
    return CL_BAD;
  endfunction

  function automatic logic [7:0] alpha_char(input int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return CH_DASH;
    return CH_UNDER;
  endfunction

  function automatic void clear_group_state();
    grp_bits   = '0;
    grp_pos    = '0;
    pad_run    = '0;
    bad_flag   = 1'b0;
    byte_count = '0;
  endfunction

  function automatic void add_beat(input logic [7:0] b, input logic has, input logic eom,
                                   input logic [1:0] st);
    b64_out_t r;
    r.data_byte      = b;
    r.has_byte       = has;
    r.end_of_message = eom;
    r.status         = st;
    expected_beats.push_back(r);
  endfunction

  // advance the predicted decoder by one character and queue the beats it gives
  function automatic void decode_char(input b64_in_t it);
    logic [5:0]             sx;
    logic [1:0]             cl;
    logic [23:0]            word;
    logic [1:0]             n;
    logic [COUNT_WIDTH+1:0] total;
    cl = classify_char(it.in_char, sx);
    case (cl)
      CL_BAD: begin
        bad_flag = 1'b1;
        pad_run  = 2'd0;
      end
      CL_PAD: begin
        if (grp_pos < 2) bad_flag = 1'b1;
        if (pad_run != 2'd2) pad_run = pad_run + 2'd1;
      end
      default: begin
        if (pad_run != 2'd0) bad_flag = 1'b1;
        pad_run = 2'd0;
      end
    endcase
    // group still open
    if (grp_pos != 2'd3) begin
      grp_bits = {grp_bits[11:0], sx};
      grp_pos  = grp_pos + 2'd1;
      if (it.is_final) begin
        add_beat(8'h00, 1'b0, 1'b1, ST_BAD_LEN);
        clear_group_state();
      end
      return;
    end
    word     = {grp_bits, sx};
    grp_bits = '0;
    grp_pos  = '0;
    // inner group: three bytes unless a bad character was seen
    if (!it.is_final) begin
      if (pad_run != 2'd0) bad_flag = 1'b1;
      total      = {1'b0, byte_count} + (COUNT_WIDTH + 2)'(3);
      byte_count = (total > COUNT_ALL) ? COUNT_ALL : total[COUNT_WIDTH:0];
      if (!bad_flag) begin
        add_beat(word[23:16], 1'b1, 1'b0, ST_OK);
        add_beat(word[15:8], 1'b1, 1'b0, ST_OK);
        add_beat(word[7:0], 1'b1, 1'b0, ST_OK);
      end
      return;
    end
    // last group
    n     = 2'd3 - pad_run;
    total = {1'b0, byte_count} + (COUNT_WIDTH + 2)'(n);
    if (total > byte_limit) add_beat(8'h00, 1'b0, 1'b1, ST_TOO_LONG);
    else if (bad_flag) add_beat(8'h00, 1'b0, 1'b1, ST_BAD_CHAR);
    else begin
      add_beat(word[23:16], 1'b1, n == 2'd1, ST_OK);
      if (n >= 2) add_beat(word[15:8], 1'b1, n == 2'd2, ST_OK);
      if (n == 3) add_beat(word[7:0], 1'b1, 1'b1, ST_OK);
    end
    clear_group_state();
  endfunction

  // offer one character until taken; pinned beats replace the predicted ones
  task automatic send_char(input logic [7:0] ch, input logic fin, input logic pinned,
                           input logic [1:0] pst);
    b64_in_t it;
    int      depth;
    it.in_char  = ch;
    it.is_final = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
    depth = expected_beats.size();
    decode_char(it);
    if (pinned) begin
      while (expected_beats.size() > depth) void'(expected_beats.pop_back());
      add_beat(8'h00, 1'b0, 1'b1, pst);
    end
  endtask

  // one random message; broken ones get a bad byte, a stray pad or a wrong length
  task automatic send_message(input int unsigned groups, input bit broken);
    logic [7:0]  text[$];
    int unsigned pads;
    int unsigned pos;
    int unsigned k;
    for (k = 0; k < groups * 4; k++) text.push_back(alpha_char($urandom_range(63)));
    pads = $urandom_range(2);
    for (k = 0; k < pads; k++) text[text.size() - 1 - k] = CH_PAD;
    if (broken) begin
      pos = $urandom_range(text.size() - 1);
      case ($urandom_range(4))
        0: text[pos] = 8'($urandom_range(255));
        1: text[pos] = CH_PAD;
        2: repeat ($urandom_range(1, 3)) if (text.size() > 1) void'(text.pop_back());
        3: text[pos] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        default: text.insert(pos, alpha_char($urandom_range(63)));
      endcase
    end
    for (k = 0; k < text.size(); k++)
      send_char(text[k], k == text.size() - 1, 1'b0, ST_OK);
  endtask

  // write the byte budget once the block has drained
  task automatic set_byte_limit(input logic [COUNT_WIDTH-1:0] v);
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    byte_limit = v;
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < beats)
      send_message(($urandom_range(99) < 10) ? $urandom_range(5, 8) : $urandom_range(1, 4),
                   $urandom_range(99) < 25);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    b64_out_t want;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", out_item));
      end else begin
        want = expected_beats.pop_front();
        if (out_item.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %h, want %h", out_item.data_byte,
                                    want.data_byte));
        if (out_item.has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, want %b", out_item.has_byte,
                                    want.has_byte));
        if (out_item.end_of_message !== want.end_of_message)
          report_mismatch($sformatf("end_of_message %b, want %b",
                                    out_item.end_of_message, want.end_of_message));
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status, want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // main sequence
  initial begin
    directed_rows = '{
      '{"A", 1'b1, 1'b1, ST_BAD_LEN},
      '{"Q", 1'b0, 1'b0, ST_OK}, '{"U", 1'b0, 1'b0, ST_OK},
      '{"J", 1'b0, 1'b0, ST_OK}, '{"D", 1'b1, 1'b0, ST_OK},
      '{"-", 1'b0, 1'b0, ST_OK}, '{"_", 1'b0, 1'b0, ST_OK},
      '{"0", 1'b0, 1'b0, ST_OK}, '{"9", 1'b1, 1'b0, ST_OK},
      '{"a", 1'b0, 1'b0, ST_OK}, '{"z", 1'b0, 1'b0, ST_OK},
      '{"=", 1'b0, 1'b0, ST_OK}, '{"=", 1'b1, 1'b0, ST_OK},
      '{"A", 1'b0, 1'b0, ST_OK}, '{"B", 1'b0, 1'b0, ST_OK},
      '{"=", 1'b0, 1'b0, ST_OK}, '{"A", 1'b1, 1'b1, ST_BAD_CHAR},
      '{"A", 1'b0, 1'b0, ST_OK}, '{"B", 1'b0, 1'b0, ST_OK},
      '{"=", 1'b0, 1'b0, ST_OK}, '{"=", 1'b0, 1'b0, ST_OK},
      '{"A", 1'b0, 1'b0, ST_OK}, '{"A", 1'b0, 1'b0, ST_OK},
      '{"A", 1'b0, 1'b0, ST_OK}, '{"A", 1'b1, 1'b1, ST_BAD_CHAR}
    };
    clear_group_state();
    byte_limit = '1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset budget, no idling
    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].pinned,
                directed_rows[i].st);

    // full budget, no idling
    set_byte_limit('1);
    run_random(PHASE_BEATS);

    // zero budget, sender idles
    set_byte_limit('0);
    send_idle_pct = 54;
    run_random(PHASE_BEATS);

    // tight budget, receiver stalls, long hold-off fills the block
    set_byte_limit(COUNT_WIDTH'(7));
    send_idle_pct = 0;
    stall_pct     = 54;
    hold_req      = 1'b1;
    run_random(PHASE_BEATS);

    // random small budget, both sides idle
    set_byte_limit(COUNT_WIDTH'($urandom_range(12)));
    send_idle_pct = 33;
    stall_pct     = 33;
    run_random(PHASE_BEATS);

    // drain and verdict
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
